// ===== rtl/i2c_master_register_access_assert.svh =====
// Assertion macros for the RTL engine.
`ifndef I2C_MASTER_REGISTER_ACCESS_ASSERT_SVH
`define I2C_MASTER_REGISTER_ACCESS_ASSERT_SVH

`ifndef ASSERT_OFF
// Checked on every rising clk edge, skipped while rst_n is low.
`define I2CM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every rising clk edge, reset included.
`define I2CM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define I2CM_ASSERT(lbl, prop, msg)
`define I2CM_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== rtl/i2cm_pkg.sv =====
package i2cm_pkg;

  localparam int PhW = 4;

  localparam logic [PhW-1:0] PH_IDLE    = 4'd0;
  localparam logic [PhW-1:0] PH_START   = 4'd1;
  localparam logic [PhW-1:0] PH_ADDR_W  = 4'd2;
  localparam logic [PhW-1:0] PH_REG     = 4'd3;
  localparam logic [PhW-1:0] PH_RESTART = 4'd4;
  localparam logic [PhW-1:0] PH_ADDR_R  = 4'd5;
  localparam logic [PhW-1:0] PH_DATA    = 4'd6;
  localparam logic [PhW-1:0] PH_READ    = 4'd7;
  localparam logic [PhW-1:0] PH_STOP    = 4'd8;

  localparam logic [15:0] QUARTER_TICKS_RST = 16'd80;

  typedef struct packed {
    logic       sda_in;
    logic [7:0] write_data;
    logic [7:0] byte_count;
    logic [7:0] reg_addr;
    logic [6:0] device_addr;
    logic       is_read;
    logic       start_req;
  } i2cm_item_t;

  typedef struct packed {
    logic       done_res;
    logic       busy_res;
    logic       ack_error;
    logic       read_valid;
    logic [7:0] read_data;
    logic       byte_taken;
    logic       sda_drive;
    logic       sda_out;
    logic       scl;
  } i2cm_res_t;

endpackage

// ===== rtl/i2cm_engine.sv =====
`include "i2c_master_register_access_assert.svh"

module i2cm_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  i2cm_pkg::i2cm_item_t item,
  input  logic [15:0]        quarter_ticks,
  output i2cm_pkg::i2cm_res_t  res
);
  import i2cm_pkg::*;

  logic [PhW-1:0] phase_r, phase_nxt;
  logic [15:0]    tick_r, tick_nxt;
  logic [1:0]     quarter_r, quarter_nxt;
  logic [3:0]     bit_r, bit_nxt;
  logic [7:0]     shift_r, shift_nxt;
  logic [7:0]     left_r, left_nxt;
  logic           rmode_r, rmode_nxt;
  logic [6:0]     dev_r, dev_nxt;
  logic [7:0]     regad_r, regad_nxt;
  logic           nack_r, nack_nxt;

  logic [1:0]     q;
  logic [15:0]    limit;
  logic           is_send;
  logic           do_enter;
  logic [PhW-1:0] enter_ph;

  always_comb begin
    phase_nxt   = phase_r;
    tick_nxt    = tick_r;
    quarter_nxt = quarter_r;
    bit_nxt     = bit_r;
    shift_nxt   = shift_r;
    left_nxt    = left_r;
    rmode_nxt   = rmode_r;
    dev_nxt     = dev_r;
    regad_nxt   = regad_r;
    nack_nxt    = nack_r;
    res         = '0;
    do_enter    = 1'b0;
    enter_ph    = PH_IDLE;

    if (phase_r == PH_IDLE && item.start_req) begin
      rmode_nxt   = item.is_read;
      dev_nxt     = item.device_addr;
      regad_nxt   = item.reg_addr;
      left_nxt    = item.byte_count;
      nack_nxt    = 1'b0;
      shift_nxt   = '0;
      phase_nxt   = PH_START;
      quarter_nxt = '0;
      bit_nxt     = '0;
      tick_nxt    = '0;
    end

    q       = quarter_nxt;
    is_send = (phase_nxt == PH_ADDR_W) || (phase_nxt == PH_REG) ||
              (phase_nxt == PH_ADDR_R) || (phase_nxt == PH_DATA);

    // pin levels for this tick
    res.scl       = 1'b1;
    res.sda_out   = 1'b1;
    res.sda_drive = 1'b0;
    unique case (phase_nxt)
      PH_IDLE: ;
      PH_START, PH_RESTART: begin
        res.scl       = !(q == 2'd3 || (q == 2'd0 && phase_nxt == PH_RESTART));
        res.sda_out   = !q[1];
        res.sda_drive = 1'b1;
      end
      PH_STOP: begin
        res.scl       = (q != 2'd0);
        res.sda_out   = q[1];
        res.sda_drive = 1'b1;
      end
      default: begin
        res.scl = (q == 2'd1) || (q == 2'd2);
        if (phase_nxt == PH_READ) begin
          if (bit_nxt[3]) begin
            res.sda_drive = 1'b1;
            res.sda_out   = (left_nxt == 8'd0);
          end
        end else if (!bit_nxt[3]) begin
          res.sda_drive = 1'b1;
          res.sda_out   = shift_nxt[7];
        end
      end
    endcase

    limit = (quarter_ticks == 16'd0) ? 16'd1 : quarter_ticks;

    if (phase_nxt != PH_IDLE) begin
      if ({1'b0, tick_nxt} + 17'd1 >= {1'b0, limit}) begin
        tick_nxt = '0;
        if (q == 2'd2) begin
          if (is_send && bit_nxt[3] && item.sda_in) nack_nxt = 1'b1;
          if (phase_nxt == PH_READ && !bit_nxt[3]) shift_nxt = {shift_nxt[6:0], item.sda_in};
        end
        if (q == 2'd3) begin
          if (phase_nxt == PH_START) begin
            do_enter = 1'b1;
            enter_ph = PH_ADDR_W;
          end else if (phase_nxt == PH_RESTART) begin
            do_enter = 1'b1;
            enter_ph = PH_ADDR_R;
          end else if (phase_nxt == PH_STOP) begin
            do_enter     = 1'b1;
            enter_ph     = PH_IDLE;
            res.done_res = 1'b1;
          end else if (!bit_nxt[3]) begin
            if (is_send) shift_nxt = {shift_nxt[6:0], 1'b0};
            bit_nxt     = bit_nxt + 4'd1;
            quarter_nxt = '0;
          end else begin
            do_enter = 1'b1;
            if (phase_nxt == PH_READ) begin
              res.read_data  = shift_nxt;
              res.read_valid = 1'b1;
              enter_ph = (left_nxt == 8'd0) ? PH_STOP : PH_READ;
            end else if (phase_nxt == PH_ADDR_W) begin
              enter_ph = PH_REG;
            end else if (phase_nxt == PH_REG && rmode_nxt) begin
              enter_ph = PH_RESTART;
            end else if (phase_nxt == PH_ADDR_R) begin
              enter_ph = (left_nxt == 8'd0) ? PH_STOP : PH_READ;
            end else begin
              enter_ph = (left_nxt == 8'd0) ? PH_STOP : PH_DATA;
            end
          end
        end else begin
          quarter_nxt = q + 2'd1;
        end
      end else begin
        tick_nxt = tick_nxt + 16'd1;
      end
    end

    if (do_enter) begin
      phase_nxt   = enter_ph;
      quarter_nxt = '0;
      bit_nxt     = '0;
      tick_nxt    = '0;
      case (enter_ph)
        PH_ADDR_W: shift_nxt = {dev_nxt, 1'b0};
        PH_ADDR_R: shift_nxt = {dev_nxt, 1'b1};
        PH_REG:    shift_nxt = regad_nxt;
        PH_DATA: begin
          shift_nxt      = item.write_data;
          res.byte_taken = 1'b1;
          left_nxt       = left_nxt - 8'd1;
        end
        PH_READ: begin
          shift_nxt = '0;
          left_nxt  = left_nxt - 8'd1;
        end
        default: ;
      endcase
    end

    res.ack_error = nack_nxt;
    res.busy_res  = (phase_nxt != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      tick_r    <= '0;
      quarter_r <= '0;
      bit_r     <= '0;
      shift_r   <= '0;
      left_r    <= '0;
      rmode_r   <= 1'b0;
      dev_r     <= '0;
      regad_r   <= '0;
      nack_r    <= 1'b0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      tick_r    <= tick_nxt;
      quarter_r <= quarter_nxt;
      bit_r     <= bit_nxt;
      shift_r   <= shift_nxt;
      left_r    <= left_nxt;
      rmode_r   <= rmode_nxt;
      dev_r     <= dev_nxt;
      regad_r   <= regad_nxt;
      nack_r    <= nack_nxt;
    end
  end

  `I2CM_ASSERT(a_idle_clean, (phase_r == PH_IDLE) |-> (tick_r == 16'd0 && quarter_r == 2'd0 && bit_r == 4'd0), "idle with live bit timing")
  `I2CM_ASSERT(a_bit_range, bit_r <= 4'd8, "bit index past ack bit")
  `I2CM_ASSERT(a_done_idle, res.done_res |-> !res.busy_res, "done while still busy")
  `I2CM_ASSERT(a_taken_data, res.byte_taken |-> (phase_nxt == PH_DATA && bit_nxt == 4'd0), "byte taken outside data byte start")
  `I2CM_ASSERT(a_rvalid_read, res.read_valid |-> (phase_r == PH_READ && bit_r == 4'd8), "read byte outside read ack bit")

endmodule

// ===== rtl/i2c_master_register_access.sv =====
// Tick-driven I2C master for register writes and register reads.
// Input stream: one item per clock tick of the bit timer; the start fields
// are taken when a start request arrives while idle, write_data is latched
// on the item whose result shows byte_taken, and sda_in is the sampled line.
// Output stream: exactly one result item per input item, carrying the pin
// levels (scl, sda_out, sda_drive) for that tick plus status flags.
// Config channel: cfg_data sets ticks per quarter bit (0 acts as 1); it is
// always ready and takes effect on the next tick.
// The result of an item is in the output register the cycle after it is
// accepted. Throughput is one item per cycle while out_tready does not stall
// the output, set by the single pass of the bit sequencer logic between its
// state registers and the output register.
// in_tready stays high while the output register is empty or being read,
// so a stalled receiver holds the pending result and blocks new ticks.
// Synchronous reset returns to idle with the bus released and quarter
// ticks set to 80; no result is pending after reset.
module i2c_master_register_access (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // start_req, is_read, device_addr[6:0], reg_addr[7:0], byte_count[7:0],
  // write_data[7:0], sda_in, zero pad
  input  logic [39:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // scl, sda_out, sda_drive, byte_taken, read_data[7:0], read_valid,
  // ack_error, busy_res, done_res
  output logic [15:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);
  import i2cm_pkg::*;

  logic        step;
  i2cm_item_t  item;
  i2cm_res_t   res;
  logic [15:0] qt_r;
  logic        out_valid_r;
  logic [15:0] out_data_r;

  assign in_tready  = !out_valid_r || out_tready;
  assign step       = in_tvalid && in_tready;
  assign item       = in_tdata[33:0];
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qt_r <= QUARTER_TICKS_RST;
    end else if (cfg_valid) begin
      qt_r <= cfg_data;
    end
  end

  i2cm_engine u_engine (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (step),
    .item          (item),
    .quarter_ticks (qt_r),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r <= res;
    end
  end

endmodule

// ===== test/tb_i2c_master_register_access.sv =====
`timescale 1ns / 100ps

module tb_i2c_master_register_access;
  import i2cm_pkg::*;

  localparam int HANG_LIMIT = 2000;

  localparam i2cm_res_t RES_IDLE = '{done_res: 1'b0, busy_res: 1'b0, ack_error: 1'b0,
                                     read_valid: 1'b0, read_data: 8'h00, byte_taken: 1'b0,
                                     sda_drive: 1'b0, sda_out: 1'b1, scl: 1'b1};
  localparam i2cm_res_t RES_START = '{done_res: 1'b0, busy_res: 1'b1, ack_error: 1'b0,
                                      read_valid: 1'b0, read_data: 8'h00, byte_taken: 1'b0,
                                      sda_drive: 1'b1, sda_out: 1'b1, scl: 1'b1};

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;

  i2c_master_register_access u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Bus sequencer copy used to predict each result item
  logic [PhW-1:0] bus_phase;
  logic [15:0]    qtr_ticks;
  logic [15:0]    tick_cnt;
  logic [1:0]     quarter;
  logic [3:0]     bit_cnt;
  logic [7:0]     shifter;
  logic [7:0]     bytes_rem;
  logic           rd_mode;
  logic [6:0]     dev_addr;
  logic [7:0]     reg_sel;
  logic           nack_flag;

  i2cm_res_t pin_q[$];

  int gap_pct;
  int stall_pct;
  int n_err;
  int n_ticks;
  int n_starts;
  int n_done;
  int n_nacked;
  int n_rbytes;
  int n_taken;
  int quiet;
  bit long_burst;
  bit acks_only;

  typedef struct {
    bit          cfg_en;
    logic [15:0] cfg_val;
    i2cm_item_t  it;
    bit          typed;
    i2cm_res_t   res;
  } step_row_t;

  step_row_t plan[$];

  function automatic bit sends_byte(input logic [PhW-1:0] p);
    return p inside {PH_ADDR_W, PH_REG, PH_ADDR_R, PH_DATA};
  endfunction

  // Returns 1 when the entered phase latches write_data
  function automatic logic enter_phase(input logic [PhW-1:0] p, input logic [7:0] wd);
    logic took;
    took = 1'b0;
    bus_phase = p;
    quarter   = '0;
    bit_cnt   = '0;
    tick_cnt  = '0;
    case (p)
      PH_ADDR_W: shifter = {dev_addr, 1'b0};
      PH_ADDR_R: shifter = {dev_addr, 1'b1};
      PH_REG:    shifter = reg_sel;
      PH_DATA: begin
        shifter   = wd;
        took      = 1'b1;
        bytes_rem = bytes_rem - 8'd1;
      end
      PH_READ: begin
        shifter   = '0;
        bytes_rem = bytes_rem - 8'd1;
      end
      default: ;
    endcase
    return took;
  endfunction

  function automatic i2cm_res_t i2c_tick(input i2cm_item_t it);
    i2cm_res_t   r;
    logic [1:0]  q;
    logic [16:0] lim;
    r = '0;
    if (bus_phase == PH_IDLE && it.start_req) begin
      rd_mode   = it.is_read;
      dev_addr  = it.device_addr;
      reg_sel   = it.reg_addr;
      bytes_rem = it.byte_count;
      nack_flag = 1'b0;
      shifter   = '0;
      n_starts++;
      void'(enter_phase(PH_START, it.write_data));
    end

    q = quarter;
    r.scl       = 1'b1;
    r.sda_out   = 1'b1;
    r.sda_drive = 1'b0;
    case (bus_phase)
      PH_IDLE: ;
      PH_START, PH_RESTART: begin
        r.scl       = !(q == 2'd3 || (q == 2'd0 && bus_phase == PH_RESTART));
        r.sda_out   = (q < 2'd2);
        r.sda_drive = 1'b1;
      end
      PH_STOP: begin
        r.scl       = (q != 2'd0);
        r.sda_out   = (q >= 2'd2);
        r.sda_drive = 1'b1;
      end
      default: begin
        r.scl = (q == 2'd1 || q == 2'd2);
        if (bus_phase == PH_READ) begin
          // master ACK, NACK after the last byte
          if (bit_cnt >= 4'd8) begin
            r.sda_drive = 1'b1;
            r.sda_out   = (bytes_rem == 8'd0);
          end
        end else if (bit_cnt < 4'd8) begin
          r.sda_drive = 1'b1;
          r.sda_out   = shifter[7];
        end
      end
    endcase

    if (bus_phase != PH_IDLE) begin
      lim = (qtr_ticks == 16'd0) ? 17'd1 : {1'b0, qtr_ticks};
      if ({1'b0, tick_cnt} + 17'd1 >= lim) begin
        tick_cnt = '0;
        if (q == 2'd2) begin
          if (sends_byte(bus_phase) && bit_cnt >= 4'd8 && it.sda_in)
            nack_flag = 1'b1;
          if (bus_phase == PH_READ && bit_cnt < 4'd8)
            shifter = {shifter[6:0], it.sda_in};
        end
        if (q != 2'd3) begin
          quarter = q + 2'd1;
        end else if (bus_phase == PH_START) begin
          void'(enter_phase(PH_ADDR_W, it.write_data));
        end else if (bus_phase == PH_RESTART) begin
          void'(enter_phase(PH_ADDR_R, it.write_data));
        end else if (bus_phase == PH_STOP) begin
          void'(enter_phase(PH_IDLE, it.write_data));
          r.done_res = 1'b1;
        end else if (bit_cnt < 4'd8) begin
          if (sends_byte(bus_phase))
            shifter = {shifter[6:0], 1'b0};
          bit_cnt = bit_cnt + 4'd1;
          quarter = '0;
        end else if (bus_phase == PH_READ) begin
          r.read_data  = shifter;
          r.read_valid = 1'b1;
          void'(enter_phase((bytes_rem == 8'd0) ? PH_STOP : PH_READ, it.write_data));
        end else if (bus_phase == PH_ADDR_W) begin
          void'(enter_phase(PH_REG, it.write_data));
        end else if (bus_phase == PH_REG && rd_mode) begin
          void'(enter_phase(PH_RESTART, it.write_data));
        end else if (bus_phase == PH_ADDR_R) begin
          void'(enter_phase((bytes_rem == 8'd0) ? PH_STOP : PH_READ, it.write_data));
        end else begin
          r.byte_taken = enter_phase((bytes_rem == 8'd0) ? PH_STOP : PH_DATA, it.write_data);
        end
      end else begin
        tick_cnt = tick_cnt + 16'd1;
      end
    end

    r.ack_error = nack_flag;
    r.busy_res  = (bus_phase != PH_IDLE);
    return r;
  endfunction

  // Random tick; mostly well-formed transactions, with stray start requests
  function automatic i2cm_item_t next_tick();
    i2cm_item_t it;
    it.start_req   = 1'b0;
    it.is_read     = 1'($urandom_range(0, 1));
    it.device_addr = 7'($urandom_range(0, 127));
    it.reg_addr    = 8'($urandom_range(0, 255));
    it.byte_count  = 8'($urandom_range(0, 255));
    it.write_data  = 8'($urandom_range(0, 255));
    it.sda_in      = 1'($urandom_range(0, 1));
    if (bus_phase == PH_IDLE) begin
      it.start_req = ($urandom_range(0, 3) != 0);
      if (it.start_req) begin
        if (long_burst) begin
          it.is_read    = 1'b0;
          it.byte_count = 8'hFF;
          long_burst    = 1'b0;
          acks_only     = 1'b1;
        end else begin
          it.byte_count = 8'($urandom_range(0, 3));
          acks_only     = 1'($urandom_range(0, 1));
        end
      end
    end else begin
      // starts landing on the STOP phase hit the done tick now and then
      it.start_req = (bus_phase == PH_STOP) ? 1'($urandom_range(0, 1))
                                            : ($urandom_range(0, 15) == 0);
      if (acks_only && sends_byte(bus_phase) && bit_cnt == 4'd8)
        it.sda_in = 1'b0;
    end
    return it;
  endfunction

  function automatic void add_row(input bit cfg_en, input logic [15:0] cfg_val,
                                  input logic st, input logic rd, input logic [6:0] dev,
                                  input logic [7:0] ra, input logic [7:0] cnt,
                                  input logic [7:0] wd, input logic sda,
                                  input bit typed, input i2cm_res_t res);
    step_row_t row;
    row.cfg_en  = cfg_en;
    row.cfg_val = cfg_val;
    row.it      = '{sda_in: sda, write_data: wd, byte_count: cnt, reg_addr: ra,
                    device_addr: dev, is_read: rd, start_req: st};
    row.typed   = typed;
    row.res     = res;
    plan.push_back(row);
  endfunction

  function automatic void cmp(input string name, input logic [7:0] want,
                              input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      n_err++;
    end
  endfunction

  task automatic push_tick(input i2cm_item_t it, input bit typed, input i2cm_res_t typed_res);
    i2cm_res_t r;
    while ($urandom_range(0, 99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, it};
    do @(posedge clk); while (!in_tready);
    r = i2c_tick(it);
    n_ticks++;
    if (r.read_valid) n_rbytes++;
    if (r.byte_taken) n_taken++;
    if (r.done_res) begin
      n_done++;
      if (r.ack_error) n_nacked++;
    end
    pin_q.push_back(typed ? typed_res : r);
  endtask

  // Register writes only once every pending result item has drained
  task automatic write_quarter(input logic [15:0] v);
    in_tvalid <= 1'b0;
    while (pin_q.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    qtr_ticks = v;
  endtask

  always @(posedge clk) begin : result_check
    i2cm_res_t want;
    i2cm_res_t got;
    out_tready <= ($urandom_range(0, 99) >= stall_pct);
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (pin_q.size() == 0) begin
        $error("result item %h arrived with nothing expected", got);
        n_err++;
      end else begin
        want = pin_q.pop_front();
        cmp("scl", 8'(want.scl), 8'(got.scl));
        cmp("sda_out", 8'(want.sda_out), 8'(got.sda_out));
        cmp("sda_drive", 8'(want.sda_drive), 8'(got.sda_drive));
        cmp("byte_taken", 8'(want.byte_taken), 8'(got.byte_taken));
        cmp("read_data", want.read_data, got.read_data);
        cmp("read_valid", 8'(want.read_valid), 8'(got.read_valid));
        cmp("ack_error", 8'(want.ack_error), 8'(got.ack_error));
        cmp("busy_res", 8'(want.busy_res), 8'(got.busy_res));
        cmp("done_res", 8'(want.done_res), 8'(got.done_res));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet == HANG_LIMIT) begin
      $display("i2c_master_register_access verification failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    int          gap_tbl[6];
    int          stall_tbl[6];
    logic [15:0] qt_tbl[6];
    int          len_tbl[6];
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    quiet      = 0;
    gap_pct    = 0;
    stall_pct  = 0;
    n_err      = 0;
    n_ticks    = 0;
    n_starts   = 0;
    n_done     = 0;
    n_nacked   = 0;
    n_rbytes   = 0;
    n_taken    = 0;
    long_burst = 1'b0;
    acks_only  = 1'b0;

    bus_phase = PH_IDLE;
    qtr_ticks = QUARTER_TICKS_RST;
    tick_cnt  = '0;
    quarter   = '0;
    bit_cnt   = '0;
    shifter   = '0;
    bytes_rem = '0;
    rd_mode   = 1'b0;
    dev_addr  = '0;
    reg_sel   = '0;
    nack_flag = 1'b0;

    gap_tbl   = '{0, 77, 0, 23, 0, 23};
    stall_tbl = '{0, 0, 77, 23, 0, 23};
    qt_tbl    = '{16'd1, 16'd2, 16'd3, 16'd1, 16'd1, 16'd5};
    len_tbl   = '{200, 150, 140, 140, 100, 50};

    // idle pins with every field at its extremes
    add_row(0, 0, 0, 1, 7'h7F, 8'hFF, 8'hFF, 8'hFF, 1, 1, RES_IDLE);
    add_row(0, 0, 0, 0, 7'h00, 8'h00, 8'h00, 8'h00, 0, 1, RES_IDLE);
    // read with zero byte count; pins show the first START quarter at once
    add_row(0, 0, 1, 1, 7'h7F, 8'hFF, 8'h00, 8'h5A, 0, 1, RES_START);
    // start while busy is ignored
    add_row(0, 0, 1, 0, 7'h00, 8'h00, 8'hFF, 8'hA5, 1, 0, RES_IDLE);
    add_row(0, 0, 0, 0, 7'h55, 8'hAA, 8'h80, 8'hFF, 0, 0, RES_IDLE);
    add_row(0, 0, 0, 1, 7'h2A, 8'h55, 8'h7F, 8'h00, 1, 0, RES_IDLE);
    // longest quarter, written mid-quarter
    add_row(1, 16'hFFFF, 0, 0, 7'h01, 8'h01, 8'h01, 8'h01, 0, 0, RES_IDLE);
    add_row(0, 0, 0, 1, 7'h40, 8'h80, 8'h80, 8'h80, 1, 0, RES_IDLE);
    // zero acts as one; the counter is already past the new limit
    add_row(1, 16'h0000, 0, 0, 7'h00, 8'h00, 8'h00, 8'h00, 0, 0, RES_IDLE);
    for (int k = 0; k < 5; k++)
      add_row(0, 0, 0, 0, 7'h00, 8'h00, 8'h00, 8'(8'h11 * k), 1'(k), 0, RES_IDLE);
    add_row(1, 16'd2, 0, 1, 7'h33, 8'hCC, 8'h01, 8'h3C, 1, 0, RES_IDLE);
    for (int k = 0; k < 4; k++)
      add_row(0, 0, 0, 0, 7'h00, 8'h00, 8'h00, 8'hC3, 0, 0, RES_IDLE);
    add_row(1, 16'd1, 0, 0, 7'h00, 8'h00, 8'h00, 8'h00, 1, 0, RES_IDLE);
    for (int k = 0; k < 3; k++)
      add_row(0, 0, 0, 0, 7'h00, 8'h00, 8'h00, 8'h00, 0, 0, RES_IDLE);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].cfg_en)
        write_quarter(plan[i].cfg_val);
      push_tick(plan[i].it, plan[i].typed, plan[i].res);
    end

    for (int m = 0; m < 6; m++) begin
      write_quarter(qt_tbl[m]);
      gap_pct    = gap_tbl[m];
      stall_pct  = stall_tbl[m];
      long_burst = (m == 4);
      for (int k = 0; k < len_tbl[m]; k++)
        push_tick(next_tick(), 0, RES_IDLE);
    end

    in_tvalid <= 1'b0;
    stall_pct = 0;
    while (pin_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("covered %0d ticks: %0d transactions started, %0d finished (%0d with NACK)",
             n_ticks, n_starts, n_done, n_nacked);
    $display("%0d write bytes latched, %0d bytes read, quarter lengths 0 to 65535",
             n_taken, n_rbytes);
    if (n_err == 0) begin
      $display("i2c_master_register_access verification clean");
    end else begin
      $display("i2c_master_register_access verification failed");
    end
    $finish;
  end

endmodule

// ===== i2c_master_register_access.f =====
+incdir+rtl
rtl/i2cm_pkg.sv
rtl/i2cm_engine.sv
rtl/i2c_master_register_access.sv
test/tb_i2c_master_register_access.sv
